>>> sv/palette_nearest_color_map_macros.svh
// ----------------------------------------------------------------------------
// palette_nearest_color_map_macros.svh
// assertion shorthands, sampled on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_MAP_MACROS_SVH
`define PALETTE_NEAREST_COLOR_MAP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PNC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// shared types, codes, constants and the channel expansion table of the palette color mapper
// ----------------------------------------------------------------------------
package pnc_pkg;

	// request function codes
	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_MAP   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd128;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned COLOR_W    = 15;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned DIST_W     = 18;
	localparam int unsigned SEEN_ROW_W = 10;
	localparam int unsigned SEEN_BIT_W = 5;

	// five-bit channel expanded as c*255/31
	localparam logic [7:0] EXP5_TBL [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	function automatic logic [7:0] exp5(input logic [4:0] c);
		return EXP5_TBL[c];
	endfunction

	// control of the seen-color map
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic               clr;
		logic               exact;
		logic [COLOR_W-1:0] color;
	} seen_req_t;

	// outcome of a palette search
	typedef struct packed {
		logic             done;
		logic             exact;
		logic [IDX_W-1:0] best;
	} srch_res_t;

endpackage

>>> sv/pnc_ifs.sv
// ----------------------------------------------------------------------------
// pnc_ifs
// valid/ready channels for pixel requests and mapped results
// ----------------------------------------------------------------------------
interface pnc_pix_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] entry_index;
	logic [7:0] alpha;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, func, entry_index, alpha, red, green, blue, input ready);
	modport sink (input valid, func, entry_index, alpha, red, green, blue, output ready);
endinterface

interface pnc_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel_index;
	logic        exact_match;
	logic [15:0] dropped_total;

	modport source (output valid, pixel_index, exact_match, dropped_total, input ready);
	modport sink (input valid, pixel_index, exact_match, dropped_total, output ready);
endinterface

>>> sv/pnc_search.sv
// ----------------------------------------------------------------------------
// pnc_search
// palette memory and a pipelined scan for the nearest entry, one per cycle
// ----------------------------------------------------------------------------
module pnc_search #(
	parameter int ENTRIES = 255
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [pnc_pkg::IDX_W-1:0]   wr_addr,
	input  logic [pnc_pkg::COLOR_W-1:0] wr_data,
	input  logic                        start,
	input  logic [pnc_pkg::IDX_W-1:0]   count,
	input  logic [pnc_pkg::COLOR_W-1:0] color,
	output pnc_pkg::srch_res_t          res
);
	import pnc_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [COLOR_W-1:0] palette_mem [ENTRIES];

	logic             issuing_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] last_q;
	logic             have_q;
	logic             done_q;
	logic [7:0]       px_r_q, px_g_q, px_b_q;

	logic               v_s1, last_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COLOR_W-1:0] pal_s1;
	logic               v_s2, last_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [7:0]         dr_s2, dg_s2, db_s2;
	logic               v_s3, last_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic [15:0]        sr_s3, sg_s3, sb_s3;

	logic [IDX_W-1:0]  best_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  res_best_q;
	logic              res_exact_q;

	logic [7:0]        pal_r, pal_g, pal_b;
	logic [DIST_W-1:0] dist_sum;
	logic              take;
	logic [IDX_W-1:0]  best_nxt;
	logic [DIST_W-1:0] best_dist_nxt;
	logic              empty_start;

	assign empty_start = start && (count == '0);

	// palette memory: one write port for loads, one registered read for the scan
	always_ff @(posedge clk) begin
		if (wr_en) palette_mem[wr_addr[AW-1:0]] <= wr_data;
		pal_s1 <= palette_mem[addr_q[AW-1:0]];
	end

	// scan control and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			addr_q    <= '0;
			last_q    <= '0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
			v_s1      <= 1'b0;
			last_s1   <= 1'b0;
			v_s2      <= 1'b0;
			last_s2   <= 1'b0;
			v_s3      <= 1'b0;
			last_s3   <= 1'b0;
		end else begin
			if (start) begin
				issuing_q <= (count != '0);
				addr_q    <= '0;
				last_q    <= count - IDX_W'(1);
				have_q    <= 1'b0;
			end else begin
				if (issuing_q) begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == last_q) issuing_q <= 1'b0;
				end
				if (v_s3) have_q <= 1'b1;
			end
			v_s1    <= issuing_q;
			last_s1 <= issuing_q && (addr_q == last_q);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			done_q  <= empty_start || (v_s3 && last_s3);
		end
	end

	// distance of the entry in the last stage and running best
	always_comb begin
		dist_sum = DIST_W'(sr_s3) + DIST_W'(sg_s3) + DIST_W'(sb_s3);
		take = v_s3 && (!have_q || (dist_sum < best_dist_q));
		best_nxt      = take ? idx_s3 : best_q;
		best_dist_nxt = take ? dist_sum : best_dist_q;
	end

	assign pal_r = exp5(pal_s1[14:10]);
	assign pal_g = exp5(pal_s1[9:5]);
	assign pal_b = exp5(pal_s1[4:0]);

	// datapath stages
	always_ff @(posedge clk) begin
		if (start) begin
			px_r_q <= exp5(color[14:10]);
			px_g_q <= exp5(color[9:5]);
			px_b_q <= exp5(color[4:0]);
		end
		idx_s1 <= addr_q;

		// absolute channel differences
		idx_s2 <= idx_s1;
		dr_s2  <= (pal_r >= px_r_q) ? pal_r - px_r_q : px_r_q - pal_r;
		dg_s2  <= (pal_g >= px_g_q) ? pal_g - px_g_q : px_g_q - pal_g;
		db_s2  <= (pal_b >= px_b_q) ? pal_b - px_b_q : px_b_q - pal_b;

		// squares
		idx_s3 <= idx_s2;
		sr_s3  <= {8'd0, dr_s2} * {8'd0, dr_s2};
		sg_s3  <= {8'd0, dg_s2} * {8'd0, dg_s2};
		sb_s3  <= {8'd0, db_s2} * {8'd0, db_s2};

		// compare and keep the first least distance
		best_q      <= best_nxt;
		best_dist_q <= best_dist_nxt;

		if (empty_start) begin
			res_best_q  <= '0;
			res_exact_q <= 1'b0;
		end else if (v_s3 && last_s3) begin
			res_best_q  <= best_nxt;
			res_exact_q <= (best_dist_nxt == '0);
		end
	end

	assign res.done  = done_q;
	assign res.best  = res_best_q;
	assign res.exact = res_exact_q;

endmodule

>>> sv/pnc_seen.sv
// ----------------------------------------------------------------------------
// pnc_seen
// seen-color bit map in rows of 32, read-modify-write, with the dropped counter
// ----------------------------------------------------------------------------
module pnc_seen (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pnc_pkg::seen_req_t        req,
	output logic                      busy,
	output logic [pnc_pkg::CNT_W-1:0] count
);
	import pnc_pkg::*;

	localparam int ROWS  = 1 << SEEN_ROW_W;
	localparam int ROW_W = 1 << SEEN_BIT_W;

	logic [ROW_W-1:0] seen_mem [ROWS];

	logic [ROW_W-1:0]      row_s1;
	logic [COLOR_W-1:0]    color_q;
	logic                  clearing_q;
	logic [SEEN_ROW_W-1:0] clr_addr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  hit;

	assign hit = row_s1[color_q[SEEN_BIT_W-1:0]];

	// row memory: clear sweep or write-back, and one registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			seen_mem[clr_addr_q] <= '0;
		end else if (req.wr) begin
			seen_mem[color_q[COLOR_W-1:SEEN_BIT_W]] <=
				row_s1 | (ROW_W'(1) << color_q[SEEN_BIT_W-1:0]);
		end
		if (req.rd) row_s1 <= seen_mem[req.color[COLOR_W-1:SEEN_BIT_W]];
	end

	// color of the pending read-modify-write
	always_ff @(posedge clk) begin
		if (req.rd) color_q <= req.color;
	end

	// clear sweep and saturating counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (req.clr) begin
				clearing_q <= 1'b1;
				clr_addr_q <= '0;
				cnt_q      <= '0;
			end else begin
				if (clearing_q) begin
					clr_addr_q <= clr_addr_q + SEEN_ROW_W'(1);
					if (clr_addr_q == '1) clearing_q <= 1'b0;
				end
				if (req.wr && !hit && !req.exact && (cnt_q != '1)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign busy  = clearing_q;
	assign count = cnt_q;

endmodule

>>> sv/palette_nearest_color_map.sv
// sequence: load, clear and unused requests are taken in the idle state; a transparent pixel
//   goes straight to the result state, an opaque pixel through the search, update and result
//   states, the search scanning N = min(palette_count, PALETTE_ENTRIES) entries (none with an
//   empty palette), one entry per cycle
// flow: one request at a time; a clear holds off requests while the seen map sweeps its rows
// reset: the seen map sweeps its 1024 rows before the first request
// ----------------------------------------------------------------------------
// palette_nearest_color_map
// maps ARGB pixels to the nearest palette entry and counts unmatched colors
// ----------------------------------------------------------------------------
module palette_nearest_color_map #(
	parameter int PALETTE_ENTRIES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	pnc_pix_if.sink     pix,
	pnc_res_if.source   res
);
	import pnc_pkg::*;

	`include "palette_nearest_color_map_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	localparam logic [IDX_W-1:0] ENTRIES_W = IDX_W'(PALETTE_ENTRIES);

	state_t             state_q;
	logic [IDX_W-1:0]   palette_count_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_exact_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_index_q;
	logic               out_exact_q;
	logic [CNT_W-1:0]   out_total_q;

	logic               accept;
	logic               is_load, is_map, is_clear;
	logic               opaque;
	logic [COLOR_W-1:0] color;
	logic [IDX_W-1:0]   scan_count;
	seen_req_t          seen_req;
	logic               seen_busy;
	logic [CNT_W-1:0]   seen_cnt;
	srch_res_t          srch_res;

	// request decode
	always_comb begin
		is_load  = 1'b0;
		is_map   = 1'b0;
		is_clear = 1'b0;
		unique case (func_t'(pix.func))
			FUNC_LOAD:  is_load  = 1'b1;
			FUNC_MAP:   is_map   = 1'b1;
			FUNC_CLEAR: is_clear = 1'b1;
			FUNC_NONE:  ;
			default:    ;
		endcase
	end

	assign pix.ready  = (state_q == ST_IDLE) && !seen_busy;
	assign accept     = pix.valid && pix.ready;
	assign opaque     = (pix.alpha >= ALPHA_OPAQUE);
	assign color      = {pix.red[7:3], pix.green[7:3], pix.blue[7:3]};
	assign scan_count = (palette_count_q > ENTRIES_W) ? ENTRIES_W : palette_count_q;

	// seen map control
	always_comb begin
		seen_req.rd    = accept && is_map && opaque;
		seen_req.wr    = (state_q == ST_UPDATE);
		seen_req.clr   = accept && is_clear;
		seen_req.exact = res_exact_q;
		seen_req.color = color;
	end

	// palette count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) palette_count_q <= '0;
		else if (cfg_we) palette_count_q <= cfg_wdata;
	end

	pnc_search #(
		.ENTRIES (PALETTE_ENTRIES)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_load && (pix.entry_index < ENTRIES_W)),
		.wr_addr (pix.entry_index),
		.wr_data (color),
		.start   (accept && is_map && opaque),
		.count   (scan_count),
		.color   (color),
		.res     (srch_res)
	);

	pnc_seen u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seen_req),
		.busy   (seen_busy),
		.count  (seen_cnt)
	);

	// request sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_idx_q   <= '0;
			res_exact_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_exact_q <= 1'b0;
			out_total_q <= '0;
		end else begin
			// a result in the result state reloads the output register instead
			if (res.ready && (state_q != ST_RESULT)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_map) begin
						if (opaque) begin
							state_q <= ST_SEARCH;
						end else begin
							res_idx_q   <= '0;
							res_exact_q <= 1'b0;
							state_q     <= ST_RESULT;
						end
					end
				end
				ST_SEARCH: begin
					if (srch_res.done) begin
						res_idx_q   <= srch_res.best + IDX_W'(1);
						res_exact_q <= srch_res.exact;
						state_q     <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_index_q <= res_idx_q;
						out_exact_q <= res_exact_q;
						out_total_q <= seen_cnt;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = out_valid_q;
	assign res.pixel_index   = out_index_q;
	assign res.exact_match   = out_exact_q;
	assign res.dropped_total = out_total_q;

	// checks
	`PNC_ASSERT_NOW(a_done_in_search, srch_res.done, state_q == ST_SEARCH, "search done outside search")
	`PNC_ASSERT_NOW(a_transp_not_exact, out_valid_q && (out_index_q == '0), !out_exact_q, "transparent result flagged exact")
	`PNC_ASSERT_NEXT(a_cnt_monotonic, !seen_req.clr, seen_cnt >= $past(seen_cnt), "dropped counter fell without clear")

endmodule
